>>> hw/rtl/pah_pkg.sv
// Shared types, constants and register indexes of the pair angle histogram.
package pah_pkg;

    // Default number of histogram bins.
    localparam int BINS_DEFAULT = 256;

    // Stream and configuration widths.
    localparam int COORD_W   = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int BIN_W     = 8;
    localparam int COUNT_W   = 32;
    localparam int S_TDATA_W = 4 * COORD_W + BIN_W;
    localparam int M_TDATA_W = BIN_W + COUNT_W;

    // Datapath widths.
    localparam int DXY_W  = COORD_W + 1;   // difference of two coordinates
    localparam int DIFF_W = COORD_W + 2;   // displacement of one periodic image
    localparam int HALF_W = 17;            // multiplier operand width
    localparam int PROD_W = 2 * HALF_W;
    localparam int ACC_W  = 2 * DIFF_W;
    localparam int REM_W  = DIFF_W;
    localparam int QN_W   = 32;
    localparam int CNT_W  = 5;
    localparam int CAND_W = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_BOX_WIDTH   = cfg_idx_t'(0);
    localparam cfg_idx_t REG_BOX_HEIGHT  = cfg_idx_t'(1);
    localparam cfg_idx_t REG_TARGET_DIST = cfg_idx_t'(2);
    localparam cfg_idx_t REG_TOLERANCE   = cfg_idx_t'(3);
    localparam cfg_idx_t REG_SLOPE_LIMIT = cfg_idx_t'(4);

    localparam logic [CFG_W-1:0] BOX_WIDTH_RST   = 31'd8388608;
    localparam logic [CFG_W-1:0] BOX_HEIGHT_RST  = 31'd8388608;
    localparam logic [CFG_W-1:0] TARGET_DIST_RST = 31'd4202496;
    localparam logic [CFG_W-1:0] TOLERANCE_RST   = 31'd26214;
    localparam logic [CFG_W-1:0] SLOPE_LIMIT_RST = 31'd19661;

    // Periodic images, in the order in which they are tried.
    localparam logic [CAND_W-1:0] IMG_SELF   = 3'd0;
    localparam logic [CAND_W-1:0] IMG_PLUS_W = 3'd1;
    localparam logic [CAND_W-1:0] IMG_PLUS_H = 3'd2;
    localparam logic [CAND_W-1:0] IMG_MINUS_W = 3'd3;
    localparam logic [CAND_W-1:0] IMG_MINUS_H = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_IMAGE,
        ST_CHECK,
        ST_TANGENT,
        ST_OFFSET,
        ST_SCALE,
        ST_BIN,
        ST_CLAMP,
        ST_LOOKUP,
        ST_UPDATE,
        ST_RESULT
    } state_t;

endpackage

>>> hw/rtl/pah_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pah_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/pair_angle_histogram.sv
// Top level of the pair angle histogram: sequencer, shared datapath and histogram store.
//
// Each accumulate transaction tries five periodic images of the second particle, keeps the
// nearest, tests its x separation and forms the tangent dy/dx, then bumps one histogram bin.
// One 17x17 multiplier builds every squared distance from partial products (six a candidate)
// and later scales the tangent to a bin; one restoring divider gives one quotient bit a cycle,
// 32 bits for the tangent and $clog2(BINS+1) for the bin. A pair rejected on its separation
// or on its tangent leaves every bin as it was. A read transaction returns the count of one
// bin, or zero for a bin out of range, and writes nothing. The input is not ready while an
// item is in progress. After reset a clearing pass writes zero to every bin, one a cycle, so
// the input is not ready until it ends; configuration writes are taken at any time and
// should be made while idle.
module pair_angle_histogram
    import pah_pkg::*;
#(
    parameter int BINS = BINS_DEFAULT
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // x_ref, y_ref, x_other, y_other, read_bin
    input  logic                 s_tuser,   // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // bin_index, bin_count
    output logic                 m_tuser,   // counted
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int AW  = $clog2(BINS);
    localparam int QB  = $clog2(BINS + 1);
    localparam int RBW = ((AW > BIN_W) ? AW : BIN_W) + 1;

    localparam logic [HALF_W-1:0] BINS_OP  = HALF_W'(BINS);
    localparam logic [QB-1:0]     BIN_LAST = QB'(BINS - 1);
    localparam logic [AW-1:0]     ADDR_LAST = AW'(BINS - 1);

    // Configuration registers.
    logic [CFG_W-1:0] box_w_reg, box_h_reg, target_reg, tol_reg, slope_reg;

    // Control state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CAND_W-1:0] cand_reg, cand_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Datapath registers.
    logic                     mode_reg, mode_next;
    logic [BIN_W-1:0]         rbin_reg, rbin_next;
    logic                     range_reg, range_next;
    logic signed [DXY_W-1:0]  dx0_reg, dx0_next, dy0_reg, dy0_next;
    logic signed [DIFF_W-1:0] bdx_reg, bdx_next, bdy_reg, bdy_next;
    logic [ACC_W-1:0]         best_reg, best_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [REM_W-1:0]         div_reg, div_next;
    logic [QN_W-1:0]          qn_reg, qn_next;
    logic [QN_W:0]            ts_reg, ts_next;
    logic                     res_counted_reg, res_counted_next;
    logic [BIN_W-1:0]         res_bin_reg, res_bin_next;
    logic [COUNT_W-1:0]       res_count_reg, res_count_next;
    logic                     m_counted_reg, m_counted_next;
    logic [BIN_W-1:0]         m_bin_reg, m_bin_next;
    logic [COUNT_W-1:0]       m_count_reg, m_count_next;

    // Histogram store.
    logic               ram_we;
    logic [COUNT_W-1:0] ram_wdata, ram_rdata;

    // Input fields.
    logic [COORD_W-1:0] x_ref, y_ref, x_other, y_other;
    logic [BIN_W-1:0]   read_bin;

    // Combinational datapath.
    logic signed [DIFF_W-1:0] off_x, off_y, cdx, cdy;
    logic [DIFF_W-1:0]        mx, my;
    logic [HALF_W-1:0]        mul_a, mul_b;
    logic [ACC_W-1:0]         acc_base, addend, acc_sum;
    logic                     acc_clear;
    logic [1:0]               add_shift;
    logic                     nearer;
    logic                     dx_pos, near, ovf, pair_ok;
    logic [DIFF_W:0]          dev, dev_mag;
    logic [DIFF_W-1:0]        dy_mag;
    logic [REM_W:0]           rem_sh, div_ext, rem_diff;
    logic                     div_ge;
    logic [REM_W-1:0]         rem_step;
    logic [QB-1:0]            bin_q;
    logic [COUNT_W-1:0]       count_inc;

    assign x_ref    = s_tdata[COORD_W-1:0];
    assign y_ref    = s_tdata[2*COORD_W-1:COORD_W];
    assign x_other  = s_tdata[3*COORD_W-1:2*COORD_W];
    assign y_other  = s_tdata[4*COORD_W-1:3*COORD_W];
    assign read_bin = s_tdata[S_TDATA_W-1:4*COORD_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {m_count_reg, m_bin_reg};
    assign m_tuser   = m_counted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_w_reg  <= BOX_WIDTH_RST;
            box_h_reg  <= BOX_HEIGHT_RST;
            target_reg <= TARGET_DIST_RST;
            tol_reg    <= TOLERANCE_RST;
            slope_reg  <= SLOPE_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BOX_WIDTH:   box_w_reg  <= cfg_data;
                REG_BOX_HEIGHT:  box_h_reg  <= cfg_data;
                REG_TARGET_DIST: target_reg <= cfg_data;
                REG_TOLERANCE:   tol_reg    <= cfg_data;
                REG_SLOPE_LIMIT: slope_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    pah_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BINS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Displacement to the periodic image under test.
    always_comb
    begin
        off_x = '0;
        off_y = '0;
        unique case (cand_reg)
            IMG_PLUS_W:  off_x = $signed({3'b000, box_w_reg});
            IMG_PLUS_H:  off_y = $signed({3'b000, box_h_reg});
            IMG_MINUS_W: off_x = -$signed({3'b000, box_w_reg});
            IMG_MINUS_H: off_y = -$signed({3'b000, box_h_reg});
            default:     ;
        endcase
    end

    assign cdx = $signed({dx0_reg[DXY_W-1], dx0_reg}) + off_x;
    assign cdy = $signed({dy0_reg[DXY_W-1], dy0_reg}) + off_y;
    assign mx  = cdx[DIFF_W-1] ? (~cdx + 1'b1) : cdx;
    assign my  = cdy[DIFF_W-1] ? (~cdy + 1'b1) : cdy;

    // Operand selection for the shared multiplier and the accumulator that follows it.
    // A squared magnitude is lo*lo + (lo*hi << 18) + (hi*hi << 34).
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        acc_clear = 1'b0;
        add_shift = 2'd0;
        if (state_reg == ST_IMAGE)
        begin
            unique case (cnt_reg)
                5'd0:    begin mul_a = mx[HALF_W-1:0];      mul_b = mx[HALF_W-1:0];      end
                5'd1:    begin mul_a = mx[HALF_W-1:0];      mul_b = mx[PROD_W-1:HALF_W]; end
                5'd2:    begin mul_a = mx[PROD_W-1:HALF_W]; mul_b = mx[PROD_W-1:HALF_W]; end
                5'd3:    begin mul_a = my[HALF_W-1:0];      mul_b = my[HALF_W-1:0];      end
                5'd4:    begin mul_a = my[HALF_W-1:0];      mul_b = my[PROD_W-1:HALF_W]; end
                5'd5:    begin mul_a = my[PROD_W-1:HALF_W]; mul_b = my[PROD_W-1:HALF_W]; end
                default: ;
            endcase
            unique case (cnt_reg)
                5'd1:       acc_clear = 1'b1;
                5'd2, 5'd5: add_shift = 2'd1;
                5'd3, 5'd6: add_shift = 2'd2;
                default:    ;
            endcase
        end
        else if (state_reg == ST_SCALE)
        begin
            unique case (cnt_reg)
                5'd0:    begin mul_a = ts_reg[HALF_W-1:0]; mul_b = BINS_OP; end
                5'd1:    begin mul_a = HALF_W'(ts_reg[QN_W:HALF_W]); mul_b = BINS_OP; end
                default: ;
            endcase
            acc_clear = (cnt_reg == 5'd1);
            if (cnt_reg == 5'd2)
            begin
                add_shift = 2'd3;
            end
        end
    end

    assign prod_next = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
    assign acc_base  = acc_clear ? '0 : acc_reg;

    always_comb
    begin
        unique case (add_shift)
            2'd0:    addend = ACC_W'(prod_reg);
            2'd1:    addend = ACC_W'(prod_reg) << (HALF_W + 1);
            2'd2:    addend = ACC_W'(prod_reg) << PROD_W;
            default: addend = ACC_W'(prod_reg) << HALF_W;
        endcase
    end

    assign acc_sum = acc_base + addend;
    assign nearer  = (cand_reg == IMG_SELF) || (acc_sum < best_reg);

    // Separation test and tangent overflow test on the chosen image.
    assign dx_pos  = !bdx_reg[DIFF_W-1] && (bdx_reg != '0);
    assign dev     = {bdx_reg[DIFF_W-1], bdx_reg} - (DIFF_W + 1)'(target_reg);
    assign dev_mag = dev[DIFF_W] ? (~dev + 1'b1) : dev;
    assign near    = dev_mag < (DIFF_W + 1)'(tol_reg);
    assign dy_mag  = bdy_reg[DIFF_W-1] ? (~bdy_reg + 1'b1) : bdy_reg;
    // The quotient of (|dy| << 16) / dx needs more than 32 bits when this holds.
    assign ovf     = REM_W'(dy_mag[DIFF_W-1:16]) >= bdx_reg;
    assign pair_ok = dx_pos && near && (slope_reg != '0) && !ovf;

    // One restoring division step.
    assign rem_sh   = {rem_reg, qn_reg[QN_W-1]};
    assign div_ext  = {1'b0, div_reg};
    assign div_ge   = rem_sh >= div_ext;
    assign rem_diff = rem_sh - div_ext;
    assign rem_step = div_ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];

    assign bin_q     = qn_reg[QB-1:0];
    assign count_inc = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            cand_reg     <= IMG_SELF;
            addr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            cand_reg     <= cand_next;
            addr_reg     <= addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        rbin_reg        <= rbin_next;
        range_reg       <= range_next;
        dx0_reg         <= dx0_next;
        dy0_reg         <= dy0_next;
        bdx_reg         <= bdx_next;
        bdy_reg         <= bdy_next;
        best_reg        <= best_next;
        acc_reg         <= acc_next;
        prod_reg        <= prod_next;
        rem_reg         <= rem_next;
        div_reg         <= div_next;
        qn_reg          <= qn_next;
        ts_reg          <= ts_next;
        res_counted_reg <= res_counted_next;
        res_bin_reg     <= res_bin_next;
        res_count_reg   <= res_count_next;
        m_counted_reg   <= m_counted_next;
        m_bin_reg       <= m_bin_next;
        m_count_reg     <= m_count_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        cand_next        = cand_reg;
        addr_next        = addr_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        mode_next        = mode_reg;
        rbin_next        = rbin_reg;
        range_next       = range_reg;
        dx0_next         = dx0_reg;
        dy0_next         = dy0_reg;
        bdx_next         = bdx_reg;
        bdy_next         = bdy_reg;
        best_next        = best_reg;
        acc_next         = acc_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        qn_next          = qn_reg;
        ts_next          = ts_reg;
        res_counted_next = res_counted_reg;
        res_bin_next     = res_bin_reg;
        res_count_next   = res_count_reg;
        m_counted_next   = m_counted_reg;
        m_bin_next       = m_bin_reg;
        m_count_next     = m_count_reg;
        ram_we           = 1'b0;
        ram_wdata        = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tuser;
                    rbin_next  = read_bin;
                    range_next = RBW'(read_bin) < RBW'(BINS);
                    addr_next  = AW'(read_bin);
                    dx0_next   = $signed({x_other[COORD_W-1], x_other})
                               - $signed({x_ref[COORD_W-1], x_ref});
                    dy0_next   = $signed({y_other[COORD_W-1], y_other})
                               - $signed({y_ref[COORD_W-1], y_ref});
                    cnt_next   = '0;
                    cand_next  = IMG_SELF;
                    state_next = s_tuser ? ST_LOOKUP : ST_IMAGE;
                end
            end

            ST_IMAGE:
            begin
                acc_next = acc_sum;
                if (cnt_reg == 5'd6)
                begin
                    cnt_next = '0;
                    if (nearer)
                    begin
                        best_next = acc_sum;
                        bdx_next  = cdx;
                        bdy_next  = cdy;
                    end
                    if (cand_reg == IMG_MINUS_H)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        cand_next = cand_reg + 1'b1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_CHECK:
            begin
                rem_next = REM_W'(dy_mag[DIFF_W-1:16]);
                qn_next  = {dy_mag[15:0], 16'h0000};
                div_next = bdx_reg;
                cnt_next = '0;
                if (pair_ok)
                begin
                    state_next = ST_TANGENT;
                end
                else
                begin
                    res_counted_next = 1'b0;
                    res_bin_next     = '0;
                    res_count_next   = '0;
                    state_next       = ST_RESULT;
                end
            end

            ST_TANGENT:
            begin
                rem_next = rem_step;
                qn_next  = {qn_reg[QN_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QN_W - 1))
                begin
                    state_next = ST_OFFSET;
                end
            end

            ST_OFFSET:
            begin
                cnt_next = '0;
                if (bdy_reg[DIFF_W-1])
                begin
                    ts_next = (QN_W + 1)'(slope_reg) - (QN_W + 1)'(qn_reg);
                end
                else
                begin
                    ts_next = (QN_W + 1)'(slope_reg) + (QN_W + 1)'(qn_reg);
                end
                if (qn_reg <= QN_W'(slope_reg))
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    res_counted_next = 1'b0;
                    res_bin_next     = '0;
                    res_count_next   = '0;
                    state_next       = ST_RESULT;
                end
            end

            ST_SCALE:
            begin
                acc_next = acc_sum;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd2)
                begin
                    // Divide (t + s) * BINS by 2s; the quotient fits in QB bits.
                    rem_next   = REM_W'(acc_sum >> QB);
                    qn_next    = QN_W'(acc_sum[QB-1:0]) << (QN_W - QB);
                    div_next   = {2'b00, slope_reg, 1'b0};
                    cnt_next   = '0;
                    state_next = ST_BIN;
                end
            end

            ST_BIN:
            begin
                rem_next = rem_step;
                qn_next  = {qn_reg[QN_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QB - 1))
                begin
                    state_next = ST_CLAMP;
                end
            end

            ST_CLAMP:
            begin
                // A tangent of exactly +s lands one past the last bin.
                addr_next  = (bin_q > BIN_LAST) ? ADDR_LAST : AW'(bin_q);
                state_next = ST_LOOKUP;
            end

            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end

            ST_UPDATE:
            begin
                if (mode_reg)
                begin
                    res_counted_next = 1'b0;
                    res_bin_next     = rbin_reg;
                    res_count_next   = range_reg ? ram_rdata : '0;
                end
                else
                begin
                    ram_we           = 1'b1;
                    ram_wdata        = count_inc;
                    res_counted_next = 1'b1;
                    res_bin_next     = BIN_W'(addr_reg);
                    res_count_next   = count_inc;
                end
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    m_counted_next = res_counted_reg;
                    m_bin_next     = res_bin_reg;
                    m_count_next   = res_count_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/pah_checker.sv
// Port-level checker for the pair angle histogram, bound to the top level.
module pah_checker
    import pah_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // Every accepted transaction keeps the block busy, so ready drops straight after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input ready again straight after a transaction");

    // A counted pair has just been added, so its bin can never read zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[M_TDATA_W-1:BIN_W] != '0)
    else $error("counted pair reported with an empty bin");

    // A result accepted on input cannot be reported before the sequencer has run.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared one cycle after the input transaction");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed or was dropped");

endmodule

bind pair_angle_histogram pah_checker u_pah_checker (.*);
